FILE: rtl/core/irfd_pkg.sv
// Shared types, codes and lookup functions of the IR remote frame decoder.
// No dependencies; imported by every module of the block.
package irfd_pkg;

    // Fixed frame layout
    localparam int DATA_BITS   = 9;
    localparam int DATA_IDX_W  = $clog2(DATA_BITS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Pulse classes
    localparam logic [1:0] CLS_SHORT = 2'd0;
    localparam logic [1:0] CLS_LONG  = 2'd1;
    localparam logic [1:0] CLS_BAD   = 2'd3;

    // Buttons
    localparam logic [4:0] BTN_DIGIT_MAX = 5'd9;
    localparam logic [4:0] BTN_STAR      = 5'd10;
    localparam logic [4:0] BTN_HASH      = 5'd11;
    localparam logic [4:0] BTN_UP        = 5'd12;
    localparam logic [4:0] BTN_DOWN      = 5'd13;
    localparam logic [4:0] BTN_LEFT      = 5'd14;
    localparam logic [4:0] BTN_RIGHT     = 5'd15;
    localparam logic [4:0] BTN_OK        = 5'd16;
    localparam logic [4:0] BTN_BAD       = 5'd17;

    // Channel codes
    localparam logic [7:0] CH_HEATER = 8'd0;
    localparam logic [7:0] CH_DIGIT0 = 8'd48;
    localparam logic [7:0] CH_ALL    = 8'd97;

    // Levels
    localparam logic [7:0] LVL_OFF  = 8'd0;
    localparam logic [7:0] LVL_DIM  = 8'd1;
    localparam logic [7:0] LVL_HALF = 8'd64;
    localparam logic [7:0] LVL_FULL = 8'd255;
    localparam logic [7:0] LVL_STEP = 8'd28;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_FLASH  = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_LEVEL  = 3'd3,
        ACT_REJECT = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        CFG_SHORT_MIN      = 3'd0,
        CFG_SHORT_MAX      = 3'd1,
        CFG_LONG_MIN       = 3'd2,
        CFG_LONG_MAX       = 3'd3,
        CFG_HEATER_TIMEOUT = 3'd4
    } t_cfg_index;

    // Command handed from the front to the back through the queue
    typedef struct packed {
        logic       is_tick;
        logic       reject;
        logic [4:0] button;
    } t_cmd;

    // One result item
    typedef struct packed {
        t_action    action;
        logic [7:0] channel;
        logic [7:0] level;
        logic [4:0] button;
    } t_result;

    // Pulse width windows
    typedef struct packed {
        logic [7:0] short_min;
        logic [7:0] short_max;
        logic [7:0] long_min;
        logic [7:0] long_max;
    } t_windows;

    // Map the nine data bits to a button
    function automatic logic [4:0] decode_button(input logic [DATA_BITS-1:0] b);
        logic [4:0] r;
        r = BTN_OK;
        if ((b & 9'h0AA) != 9'd0)
            r = BTN_BAD;
        else if (b[0]) begin
            if (b[2])      r = BTN_RIGHT;
            else if (b[4]) r = b[6] ? 5'd3 : BTN_DOWN;
            else           r = 5'd2;
        end else if (b[2]) begin
            if (b[4]) begin
                if (b[6]) r = 5'd6;
                else      r = b[8] ? 5'd1 : BTN_UP;
            end else if (b[6]) r = b[8] ? 5'd9 : BTN_HASH;
            else               r = b[8] ? 5'd0 : BTN_STAR;
        end else if (b[4]) begin
            if (b[6]) r = b[8] ? 5'd8 : 5'd4;
            else      r = BTN_LEFT;
        end else if (b[6]) r = b[8] ? 5'd5 : 5'd7;
        return r;
    endfunction

    // Brightness of a digit button
    function automatic logic [7:0] digit_level(input logic [4:0] b);
        logic [7:0] r;
        if (b == BTN_DIGIT_MAX) r = LVL_FULL;
        else                    r = 8'({3'b000, b} * LVL_STEP);
        return r;
    endfunction

endpackage

FILE: rtl/core/ir_remote_frame_decoder_core.sv
// Top level of the IR remote frame decoder: configuration registers, front end,
// command queue and back end. Depends on irfd_pkg, irfd_front, irfd_queue, irfd_back.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries either a pulse width sample
//   (i_opcode 0, i_pulse_width, i_frame_end) or a timer tick (i_opcode 1).
//   Result channel (o_out_valid/i_out_ready) carries light commands; o_last
//   marks the final result caused by one input item. Config channel
//   (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) is always ready; the
//   user must write it only while the block is idle; the block does not enforce this.
// Path: the queue is written at the transfer of an item, and its result is
//   then loaded from the queue head into the output register when that is free.
// Throughput: one input item per cycle while the queue has room. The back end
//   retires one queued command per cycle when its output is free; a command
//   giving a stop and a main result holds the output register for both. A
//   four-entry command queue absorbs these bursts; o_in_ready drops when it is full.
// Reset (synchronous, active low) clears the frame, the light selection,
//   the heater and the queue, and loads the default pulse windows and timeout.
// A stalled receiver holds the output register; the queue then fills and
//   the input side stalls in turn. Samples without frame end keep flowing
//   only while the queue has room.
module ir_remote_frame_decoder_core
    import irfd_pkg::*;
#(
    parameter int PREAMBLE_START = 19,
    parameter int PREAMBLE_LEN   = 16,
    parameter int FRAME_LEN      = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_pulse_width,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_action,
    output logic [7:0]  o_channel,
    output logic [7:0]  o_level,
    output logic [4:0]  o_button,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_windows    r_win;
    logic [23:0] r_heater_timeout;
    logic        w_accept;
    logic        w_push;
    t_cmd        w_push_cmd;
    logic        w_q_ready;
    logic        w_q_valid;
    t_cmd        w_q_cmd;
    logic        w_pop;
    t_result     w_result;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.short_min  <= 8'h07;
            r_win.short_max  <= 8'h0E;
            r_win.long_min   <= 8'h1C;
            r_win.long_max   <= 8'h24;
            r_heater_timeout <= 24'hFFFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SHORT_MIN:      r_win.short_min  <= i_cfg_data[7:0];
                CFG_SHORT_MAX:      r_win.short_max  <= i_cfg_data[7:0];
                CFG_LONG_MIN:       r_win.long_min   <= i_cfg_data[7:0];
                CFG_LONG_MAX:       r_win.long_max   <= i_cfg_data[7:0];
                CFG_HEATER_TIMEOUT: r_heater_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = w_q_ready;
    assign w_accept   = i_in_valid && w_q_ready;

    irfd_front #(
        .PREAMBLE_START (PREAMBLE_START),
        .PREAMBLE_LEN   (PREAMBLE_LEN),
        .FRAME_LEN      (FRAME_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_win         (r_win),
        .i_accept      (w_accept),
        .i_opcode      (i_opcode),
        .i_pulse_width (i_pulse_width),
        .i_frame_end   (i_frame_end),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    irfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    irfd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_heater_timeout (r_heater_timeout),
        .i_cmd_valid      (w_q_valid),
        .i_cmd            (w_q_cmd),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result         (w_result),
        .o_last           (o_last)
    );

    assign o_action  = w_result.action;
    assign o_channel = w_result.channel;
    assign o_level   = w_result.level;
    assign o_button  = w_result.button;

endmodule

FILE: rtl/core/irfd_front.sv
// Front end: classifies pulse widths, tracks the frame and emits commands.
// Depends on irfd_pkg.
module irfd_front
    import irfd_pkg::*;
#(
    parameter int PREAMBLE_START = 19,
    parameter int PREAMBLE_LEN   = 16,
    parameter int FRAME_LEN      = 80
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_windows   i_win,
    input  logic       i_accept,
    input  logic       i_opcode,
    input  logic [7:0] i_pulse_width,
    input  logic       i_frame_end,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int   DATA_START = PREAMBLE_START + PREAMBLE_LEN;
    localparam int   DATA_END   = DATA_START + DATA_BITS;
    localparam bit   FITS       = (DATA_END <= FRAME_LEN);
    localparam int   PW         = $clog2(FRAME_LEN + 1);
    localparam logic PS_ODD     = 1'(PREAMBLE_START % 2);

    logic [PW-1:0]        r_position, n_position;
    logic                 r_pre_good, n_pre_good;
    logic [DATA_BITS-1:0] r_bits,     n_bits;
    logic                 r_data_good, n_data_good;
    logic [1:0]           w_cls;
    logic                 w_expect_long;
    logic [PW-1:0]        w_rel;
    logic [DATA_IDX_W-1:0] w_idx;
    logic                 w_reject;

    // Classify the width by the strict windows
    always_comb begin
        if (i_pulse_width > i_win.short_min && i_pulse_width < i_win.short_max)
            w_cls = CLS_SHORT;
        else if (i_pulse_width > i_win.long_min && i_pulse_width < i_win.long_max)
            w_cls = CLS_LONG;
        else
            w_cls = CLS_BAD;
    end

    assign w_expect_long = ~(r_position[0] ^ PS_ODD);
    assign w_rel         = r_position - PW'(DATA_START);
    assign w_idx         = w_rel[DATA_IDX_W-1:0];

    // Fold the sample into the frame state
    always_comb begin
        n_position  = r_position;
        n_pre_good  = r_pre_good;
        n_bits      = r_bits;
        n_data_good = r_data_good;
        if (int'(r_position) < FRAME_LEN) begin
            if (r_position == '0)
                n_data_good = 1'b1;
            if (int'(r_position) >= PREAMBLE_START && int'(r_position) < DATA_START) begin
                if (w_cls != (w_expect_long ? CLS_LONG : CLS_SHORT))
                    n_pre_good = 1'b0;
            end
            if (int'(r_position) >= DATA_START && int'(r_position) < DATA_END) begin
                if (w_cls == CLS_BAD)
                    n_data_good = 1'b0;
                else
                    n_bits[w_idx] = w_cls[0];
            end
            n_position = r_position + PW'(1);
        end
    end

    assign w_reject = !n_pre_good || !n_data_good || !FITS || (int'(n_position) < DATA_END);

    // Issue a command on ticks and on the last sample of a frame
    assign o_push         = i_accept && (i_opcode || i_frame_end);
    assign o_cmd.is_tick  = i_opcode;
    assign o_cmd.reject   = w_reject;
    assign o_cmd.button   = decode_button(n_bits);

    // Advance or clear the frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_pre_good  <= 1'b1;
            r_bits      <= '0;
            r_data_good <= 1'b0;
        end else if (i_accept && !i_opcode) begin
            if (i_frame_end) begin
                r_position  <= '0;
                r_pre_good  <= 1'b1;
                r_bits      <= '0;
                r_data_good <= 1'b0;
            end else begin
                r_position  <= n_position;
                r_pre_good  <= n_pre_good;
                r_bits      <= n_bits;
                r_data_good <= n_data_good;
            end
        end
    end

endmodule

FILE: rtl/core/irfd_queue.sv
// Short command queue between front and back of the decoder.
// Depends on irfd_pkg.
module irfd_queue
    import irfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_ready = (r_count != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_cmd;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            if (i_pop)
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            if (i_push && !i_pop)
                r_count <= r_count + (QUEUE_PTR_W + 1)'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - (QUEUE_PTR_W + 1)'(1);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push into full queue");

endmodule

FILE: rtl/core/irfd_back.sv
// Back end: runs the light command state machine and heater timer,
// and drives the registered result channel. Depends on irfd_pkg.
module irfd_back
    import irfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [23:0] i_heater_timeout,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_result,
    output logic        o_last
);

    logic        r_selecting, n_selecting;
    logic [7:0]  r_light,     n_light;
    logic        r_heater_on, n_heater_on;
    logic [23:0] r_count,     n_count;
    logic        r_second;
    logic        r_out_valid;
    t_result     r_result;
    logic        r_last;

    logic        w_has_stop;
    logic        w_has_main;
    t_result     w_stop;
    t_result     w_main;
    logic        w_go;

    // Work out the results of the head command and the state it leaves
    always_comb begin
        n_selecting = r_selecting;
        n_light     = r_light;
        n_heater_on = r_heater_on;
        n_count     = r_count;
        w_has_stop  = 1'b0;
        w_has_main  = 1'b0;
        w_stop      = '{ACT_STOP, CH_HEATER, LVL_OFF, i_cmd.button};
        w_main      = '{ACT_NONE, CH_HEATER, LVL_OFF, i_cmd.button};
        if (i_cmd.is_tick) begin
            if (r_heater_on) begin
                if (r_count <= 24'd1) begin
                    w_has_main  = 1'b1;
                    w_main      = '{ACT_LEVEL, CH_HEATER, LVL_OFF, BTN_BAD};
                    n_heater_on = 1'b0;
                    n_count     = '0;
                end else begin
                    n_count = r_count - 24'd1;
                end
            end
        end else if (i_cmd.reject) begin
            w_has_main = 1'b1;
            w_main     = '{ACT_REJECT, CH_HEATER, LVL_OFF, BTN_BAD};
        end else if (i_cmd.button <= BTN_DIGIT_MAX) begin
            w_has_stop = r_selecting;
            w_has_main = 1'b1;
            if (r_selecting) begin
                w_main      = '{ACT_LEVEL, r_light, digit_level(i_cmd.button), i_cmd.button};
                n_selecting = 1'b0;
            end else begin
                w_main      = '{ACT_FLASH, CH_DIGIT0 + {3'b000, i_cmd.button}, LVL_OFF,
                                i_cmd.button};
                n_selecting = 1'b1;
                n_light     = CH_DIGIT0 + {3'b000, i_cmd.button};
            end
        end else begin
            w_has_stop  = r_selecting;
            n_selecting = 1'b0;
            case (i_cmd.button)
                BTN_STAR: begin
                    if (!r_heater_on) begin
                        w_has_main  = 1'b1;
                        w_main      = '{ACT_LEVEL, CH_HEATER, LVL_FULL, i_cmd.button};
                        n_heater_on = 1'b1;
                        n_count     = i_heater_timeout;
                    end
                end
                BTN_UP: begin
                    w_has_main = 1'b1;
                    w_main     = '{ACT_LEVEL, CH_ALL, LVL_FULL, i_cmd.button};
                end
                BTN_DOWN: begin
                    w_has_main = 1'b1;
                    w_main     = '{ACT_LEVEL, CH_ALL, LVL_OFF, i_cmd.button};
                end
                BTN_LEFT: begin
                    w_has_main = 1'b1;
                    w_main     = '{ACT_LEVEL, CH_ALL, LVL_DIM, i_cmd.button};
                end
                BTN_RIGHT: begin
                    w_has_main = 1'b1;
                    w_main     = '{ACT_LEVEL, CH_ALL, LVL_HALF, i_cmd.button};
                end
                default: ;
            endcase
            if (!w_has_main && !r_selecting)
                w_has_main = 1'b1;
        end
    end

    // Output register is free when empty or being drained
    assign w_go  = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_pop = w_go && (r_second || !(w_has_stop && w_has_main));

    // Apply the command's state change once, when it leaves the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selecting <= 1'b0;
            r_light     <= '0;
            r_heater_on <= 1'b0;
            r_count     <= '0;
        end else if (o_pop) begin
            r_selecting <= n_selecting;
            r_light     <= n_light;
            r_heater_on <= n_heater_on;
            r_count     <= n_count;
        end
    end

    // Load results into the output register, one transfer at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            if (w_go && (r_second || w_has_stop || w_has_main)) begin
                r_out_valid <= 1'b1;
                r_second    <= !r_second && w_has_stop && w_has_main;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            if (r_second) begin
                r_result <= w_main;
                r_last   <= 1'b1;
            end else if (w_has_stop || w_has_main) begin
                r_result <= w_has_stop ? w_stop : w_main;
                r_last   <= !(w_has_stop && w_has_main);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_last      = r_last;

    a_second_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_out_valid && !r_last))
        else $error("pending second result without a first one shown");

    a_second_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> i_cmd_valid)
        else $error("head command lost before its second result");

    a_heater_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_heater_on |-> (r_count == 24'd0) || $past(!i_rst_n))
        else $error("heater count left over while heater is off");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench of ir_remote_frame_decoder_core: sends pulse frames, timer
// ticks and window settings, predicts every light command and checks each transfer.
// Depends on irfd_pkg and the decoder core RTL.
module testbench;
    import irfd_pkg::*;

    localparam int PRE_START    = 19;
    localparam int PRE_LEN      = 16;
    localparam int DATA_START   = PRE_START + PRE_LEN;
    localparam int DATA_END     = DATA_START + DATA_BITS;
    localparam int FRAME_LEN    = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_SHOWN    = 10;

    localparam logic [7:0] NO_CHANNEL = 8'd0;
    localparam logic [8:0] STAR_BITS  = 9'b0_0000_0100;
    localparam logic [8:0] EVEN_MASK  = 9'b1_0101_0101;
    localparam logic [8:0] ODD_MASK   = 9'b0_1010_1010;

    typedef enum int {
        FRM_GOOD,
        FRM_LONG,
        FRM_BAD_PREAMBLE,
        FRM_BAD_DATA,
        FRM_TRUNCATED
    } t_frame_kind;

    typedef struct {
        t_action    action;
        logic [7:0] channel;
        logic [7:0] level;
        logic [4:0] button;
        logic       last;
    } t_light_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = 1'b0;
    logic [7:0]  i_pulse_width = 8'd0;
    logic        i_frame_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_action;
    logic [7:0]  o_channel;
    logic [7:0]  o_level;
    logic [4:0]  o_button;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [23:0] i_cfg_data = 24'd0;

    // Decoder state as the block should hold it
    logic [7:0]  win_short_min = 8'd7;
    logic [7:0]  win_short_max = 8'd14;
    logic [7:0]  win_long_min  = 8'd28;
    logic [7:0]  win_long_max  = 8'd36;
    logic [23:0] heater_timeout = 24'hFF_FFFF;
    int          frm_pos = 0;
    bit          preamble_ok = 1'b1;
    logic [8:0]  frm_bits = 9'd0;
    bit          bits_ok = 1'b0;
    bit          selecting = 1'b0;
    logic [7:0]  sel_channel = 8'd0;
    bit          heater_on = 1'b0;
    logic [23:0] heater_left = 24'd0;

    t_light_cmd  light_cmd_q[$];
    int          mismatch_cnt = 0;
    int          items_sent = 0;
    int          cycle_cnt = 0;
    bit          idle_on = 1'b1;
    bit          hold_off_req = 1'b0;
    int          ready_hold_left = 0;
    int          ready_stall_left = 0;

    ir_remote_frame_decoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_pulse_width (i_pulse_width),
        .i_frame_end   (i_frame_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_action      (o_action),
        .o_channel     (o_channel),
        .o_level       (o_level),
        .o_button      (o_button),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [1:0] pulse_class(input logic [7:0] w);
        if (w > win_short_min && w < win_short_max) return CLS_SHORT;
        if (w > win_long_min && w < win_long_max) return CLS_LONG;
        return CLS_BAD;
    endfunction

    // Any odd bit set is invalid; the even bits select one of seventeen buttons
    function automatic logic [4:0] button_of(input logic [8:0] bits);
        logic [4:0] key;
        key = {bits[0], bits[2], bits[4], bits[6], bits[8]};
        if ((bits & ODD_MASK) != 9'd0) return BTN_BAD;
        casez (key)
            5'b11???: return BTN_RIGHT;
            5'b1011?: return 5'd3;
            5'b1010?: return BTN_DOWN;
            5'b100??: return 5'd2;
            5'b0111?: return 5'd6;
            5'b01101: return 5'd1;
            5'b01100: return BTN_UP;
            5'b01011: return 5'd9;
            5'b01010: return BTN_HASH;
            5'b01001: return 5'd0;
            5'b01000: return BTN_STAR;
            5'b00111: return 5'd8;
            5'b00110: return 5'd4;
            5'b0010?: return BTN_LEFT;
            5'b00011: return 5'd5;
            5'b00010: return 5'd7;
            default:  return BTN_OK;
        endcase
    endfunction

    function automatic t_light_cmd light_cmd(input t_action act, input logic [7:0] ch,
                                             input logic [7:0] lvl, input logic [4:0] btn);
        t_light_cmd c;
        c.action  = act;
        c.channel = ch;
        c.level   = lvl;
        c.button  = btn;
        c.last    = 1'b0;
        return c;
    endfunction

    // Advance the decoder state by one transfer and queue the commands it gives
    task automatic predict_light_cmds(input logic op, input logic [7:0] width,
                                      input logic fend);
        t_light_cmd cmds[$];
        logic [1:0] cls;
        logic [4:0] btn;
        if (op) begin
            // count the heater down; switch channel zero off at the end
            if (heater_on) begin
                if (heater_left <= 24'd1) begin
                    heater_left = 24'd0;
                    heater_on   = 1'b0;
                    cmds.push_back(light_cmd(ACT_LEVEL, CH_HEATER, LVL_OFF, BTN_BAD));
                end else begin
                    heater_left = heater_left - 24'd1;
                end
            end
        end else begin
            if (frm_pos < FRAME_LEN) begin
                cls = pulse_class(width);
                if (frm_pos == 0) bits_ok = 1'b1;
                if (frm_pos >= PRE_START && frm_pos < DATA_START) begin
                    if (cls != (((frm_pos - PRE_START) % 2 == 0) ? CLS_LONG : CLS_SHORT))
                        preamble_ok = 1'b0;
                end
                if (frm_pos >= DATA_START && frm_pos < DATA_END) begin
                    if (cls == CLS_BAD) bits_ok = 1'b0;
                    else frm_bits[frm_pos - DATA_START] = cls[0];
                end
                frm_pos++;
            end
            if (fend) begin
                if (!preamble_ok || !bits_ok || frm_pos < DATA_END) begin
                    cmds.push_back(light_cmd(ACT_REJECT, NO_CHANNEL, LVL_OFF, BTN_BAD));
                end else begin
                    btn = button_of(frm_bits);
                    if (btn <= BTN_DIGIT_MAX) begin
                        // a digit selects a light, the next digit sets its level
                        if (!selecting) begin
                            selecting   = 1'b1;
                            sel_channel = 8'(CH_DIGIT0 + btn);
                            cmds.push_back(light_cmd(ACT_FLASH, sel_channel, LVL_OFF, btn));
                        end else begin
                            selecting = 1'b0;
                            cmds.push_back(light_cmd(ACT_STOP, NO_CHANNEL, LVL_OFF, btn));
                            cmds.push_back(light_cmd(ACT_LEVEL, sel_channel,
                                (btn == BTN_DIGIT_MAX) ? LVL_FULL : 8'(LVL_STEP * btn), btn));
                        end
                    end else begin
                        if (selecting) begin
                            selecting = 1'b0;
                            cmds.push_back(light_cmd(ACT_STOP, NO_CHANNEL, LVL_OFF, btn));
                        end
                        case (btn)
                            BTN_STAR: begin
                                if (!heater_on) begin
                                    heater_on   = 1'b1;
                                    heater_left = heater_timeout;
                                    cmds.push_back(light_cmd(ACT_LEVEL, CH_HEATER, LVL_FULL,
                                                             btn));
                                end
                            end
                            BTN_UP:    cmds.push_back(light_cmd(ACT_LEVEL, CH_ALL, LVL_FULL, btn));
                            BTN_DOWN:  cmds.push_back(light_cmd(ACT_LEVEL, CH_ALL, LVL_OFF, btn));
                            BTN_LEFT:  cmds.push_back(light_cmd(ACT_LEVEL, CH_ALL, LVL_DIM, btn));
                            BTN_RIGHT: cmds.push_back(light_cmd(ACT_LEVEL, CH_ALL, LVL_HALF, btn));
                            default: ;
                        endcase
                        if (cmds.size() == 0)
                            cmds.push_back(light_cmd(ACT_NONE, NO_CHANNEL, LVL_OFF, btn));
                    end
                end
                frm_pos     = 0;
                preamble_ok = 1'b1;
                frm_bits    = 9'd0;
                bits_ok     = 1'b0;
            end
        end
        if (cmds.size() > 0) cmds[cmds.size() - 1].last = 1'b1;
        foreach (cmds[i]) light_cmd_q.push_back(cmds[i]);
    endtask

    // Offer one item, wait for its transfer, then predict its commands
    task automatic send_item(input logic op, input logic [7:0] width, input logic fend);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_pulse_width <= width;
        i_frame_end   <= fend;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        items_sent++;
        predict_light_cmds(op, width, fend);
    endtask

    // Drop valid and wait until every command has arrived and the pipe is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (light_cmd_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [23:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SHORT_MIN:      win_short_min  = value[7:0];
            CFG_SHORT_MAX:      win_short_max  = value[7:0];
            CFG_LONG_MIN:       win_long_min   = value[7:0];
            CFG_LONG_MAX:       win_long_max   = value[7:0];
            CFG_HEATER_TIMEOUT: heater_timeout = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_windows(input logic [7:0] smin, input logic [7:0] smax,
                               input logic [7:0] lmin, input logic [7:0] lmax);
        write_cfg(CFG_SHORT_MIN, {16'd0, smin});
        write_cfg(CFG_SHORT_MAX, {16'd0, smax});
        write_cfg(CFG_LONG_MIN, {16'd0, lmin});
        write_cfg(CFG_LONG_MAX, {16'd0, lmax});
    endtask

    // Pick a width of the wanted class under the current windows, if one exists
    function automatic logic [7:0] width_in_class(input logic [1:0] cls);
        int         lo;
        int         hi;
        int         start;
        logic [7:0] w;
        lo = (cls == CLS_SHORT) ? int'(win_short_min) : int'(win_long_min);
        hi = (cls == CLS_SHORT) ? int'(win_short_max) : int'(win_long_max);
        if (cls != CLS_BAD && hi > lo + 1) begin
            w = 8'($urandom_range(lo + 1, hi - 1));
            if (pulse_class(w) == cls) return w;
        end
        start = $urandom_range(0, 255);
        for (int i = 0; i < 256; i++) begin
            w = 8'(start + i);
            if (pulse_class(w) == cls) return w;
        end
        return 8'(start);
    endfunction

    // Send one frame: mostly well formed, some broken, cut short or overlong
    task automatic send_random_frame(input int star_pct, input int tick_pct);
        int          r;
        int          n;
        int          bad_at;
        t_frame_kind kind;
        logic [8:0]  bits;
        logic [1:0]  cls;
        logic [7:0]  w;
        r = $urandom_range(0, 99);
        if (r < 65)      kind = FRM_GOOD;
        else if (r < 73) kind = FRM_LONG;
        else if (r < 83) kind = FRM_BAD_PREAMBLE;
        else if (r < 90) kind = FRM_BAD_DATA;
        else             kind = FRM_TRUNCATED;
        // button bits: mostly clean even bits, sometimes odd bits too
        if ($urandom_range(0, 99) < star_pct) begin
            bits = STAR_BITS;
        end else begin
            bits = 9'($urandom_range(0, 511));
            if ($urandom_range(0, 99) < 85) bits = bits & EVEN_MASK;
        end
        case (kind)
            FRM_LONG:      n = $urandom_range(FRAME_LEN + 1, FRAME_LEN + 10);
            FRM_TRUNCATED: n = $urandom_range(1, DATA_END - 1);
            default:       n = $urandom_range(DATA_END, DATA_END + 4);
        endcase
        bad_at = (kind == FRM_BAD_PREAMBLE) ? $urandom_range(PRE_START, DATA_START - 1)
                                            : $urandom_range(DATA_START, DATA_END - 1);
        for (int p = 0; p < n; p++) begin
            // sprinkle timer ticks between samples
            if ($urandom_range(0, 99) < tick_pct) send_item(1'b1, 8'($urandom), 1'($urandom));
            w = 8'($urandom);
            if (p >= PRE_START && p < DATA_END) begin
                if (p < DATA_START)
                    cls = ((p - PRE_START) % 2 == 0) ? CLS_LONG : CLS_SHORT;
                else
                    cls = bits[p - DATA_START] ? CLS_LONG : CLS_SHORT;
                if (p == bad_at && kind == FRM_BAD_DATA) begin
                    cls = CLS_BAD;
                end else if (p == bad_at && kind == FRM_BAD_PREAMBLE) begin
                    if ($urandom_range(0, 1) == 0) cls = CLS_BAD;
                    else cls = (cls == CLS_LONG) ? CLS_SHORT : CLS_LONG;
                end
                w = width_in_class(cls);
            end
            send_item(1'b0, w, p == n - 1);
        end
    endtask

    // Window edges, extreme widths, lone frame ends and ticks with the heater off
    task automatic test_edges();
        logic [7:0] bounds [8] = '{8'd7, 8'd8, 8'd13, 8'd14, 8'd28, 8'd29, 8'd35, 8'd36};
        send_item(1'b1, 8'hFF, 1'b1);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b0, 8'h00, 1'b1);
        send_item(1'b0, 8'hFF, 1'b1);
        foreach (bounds[i]) send_item(1'b0, bounds[i], 1'b0);
        send_item(1'b0, 8'h80, 1'b1);
        send_item(1'b1, 8'h55, 1'b0);
    endtask

    task automatic test_default_windows();
        wait_idle();
        // keep the heater timeout short so a star frame cannot leave it on for good
        write_cfg(CFG_HEATER_TIMEOUT, 24'd20);
        repeat (1) send_random_frame(15, 8);
    endtask

    task automatic test_window_settings();
        logic [7:0] smin;
        logic [7:0] smax;
        logic [7:0] lmin;
        logic [7:0] lmax;
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: begin
                    // every width but the ends is short: no long pulse exists
                    smin = 8'd0;   smax = 8'd255; lmin = 8'd0;   lmax = 8'd255;
                end
                1: begin
                    // nothing classifies
                    smin = 8'd255; smax = 8'd255; lmin = 8'd255; lmax = 8'd255;
                end
                2: begin
                    // exactly one width per class, at the ends of the range
                    smin = 8'd0;   smax = 8'd2;   lmin = 8'd253; lmax = 8'd255;
                end
                default: begin
                    smin = 8'($urandom_range(0, 60));
                    smax = 8'(smin + $urandom_range(2, 30));
                    lmin = 8'(smax + $urandom_range(0, 30));
                    lmax = 8'(lmin + $urandom_range(2, 60));
                end
            endcase
            wait_idle();
            set_windows(smin, smax, lmin, lmax);
            write_cfg(CFG_HEATER_TIMEOUT, 24'($urandom_range(1, 40)));
            repeat (1) send_random_frame(10, 8);
        end
    endtask

    task automatic test_heater_timeout();
        logic [23:0] timeouts [3] = '{24'd1, 24'd3, 24'd17};
        wait_idle();
        set_windows(8'd7, 8'd14, 8'd28, 8'd36);
        foreach (timeouts[i]) begin
            wait_idle();
            write_cfg(CFG_HEATER_TIMEOUT, timeouts[i]);
            repeat (2) send_random_frame(40, 20);
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_off_req = 1'b1;
        // every transfer ends a frame, so the held output backs up into the input
        repeat (40) send_item(1'b0, 8'($urandom), 1'b1);
    endtask

    task automatic test_tail();
        wait_idle();
        idle_on = 1'b0;
        set_windows(8'd7, 8'd14, 8'd28, 8'd36);
        write_cfg(CFG_HEATER_TIMEOUT, 24'hFF_FFFF);
        for (int k = 0; k < 1 || items_sent < 750; k++) send_random_frame(15, 8);
    endtask

    // Drive ready: a long hold-off on request, random stall bursts otherwise
    always @(posedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req    = 1'b0;
            ready_hold_left = HOLD_CYCLES;
        end
        if (ready_hold_left > 0) begin
            ready_hold_left--;
            i_out_ready <= 1'b0;
        end else if (ready_stall_left > 0) begin
            ready_stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_stall_left = $urandom_range(0, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest predicted command
    always @(posedge i_clk) begin
        t_light_cmd want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (light_cmd_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_SHOWN)
                    $display({"cycle %0d: unexpected command action %0d ch %0d",
                              " lvl %0d btn %0d last %0d"},
                             cycle_cnt, o_action, o_channel, o_level, o_button, o_last);
            end else begin
                want = light_cmd_q.pop_front();
                if (o_action !== want.action || o_channel !== want.channel ||
                    o_level !== want.level || o_button !== want.button ||
                    o_last !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_SHOWN)
                        $display({"cycle %0d: expected action %0d ch %0d lvl %0d btn %0d last %0d,",
                                  " got action %0d ch %0d lvl %0d btn %0d last %0d"},
                                 cycle_cnt, want.action, want.channel, want.level,
                                 want.button, want.last, o_action, o_channel, o_level,
                                 o_button, o_last);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        test_default_windows();
        test_window_settings();
        test_heater_timeout();
        test_backpressure();
        test_tail();
        // drain the last commands, then leave room for stray ones
        wait_idle();
        if (mismatch_cnt == 0 && light_cmd_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
